@@ rtl/kf2_pkg.sv @@
package kf2_pkg;

  // Default fraction width of the Q format
  localparam int FRAC_BITS_DEF = 16;

  // Register indexes on the configuration port
  localparam logic [3:0] REG_TRANS0 = 4'd0;
  localparam logic [3:0] REG_TRANS1 = 4'd1;
  localparam logic [3:0] REG_OBS0   = 4'd2;
  localparam logic [3:0] REG_OBS1   = 4'd3;
  localparam logic [3:0] REG_PNS0   = 4'd4;
  localparam logic [3:0] REG_PNS1   = 4'd5;
  localparam logic [3:0] REG_MNS0   = 4'd6;
  localparam logic [3:0] REG_MNS1   = 4'd7;

  // Reset values (A, H, R: diagonal 1 LSB and 2^16 LSB; Q: zero)
  localparam logic [63:0] RST_ROW0 = 64'h0000_0001_0000_0000;
  localparam logic [63:0] RST_ROW1 = 64'h0000_0000_0001_0000;
  localparam logic [63:0] RST_ZERO = 64'h0;

  typedef enum logic [2:0] {
    ST_IDLE, ST_RD, ST_EX, ST_WB, ST_DIV, ST_DWB, ST_OUT
  } kf_state_t;

  typedef enum logic [2:0] {
    OP_MUL,   // acc = round(a*b)
    OP_MAC,   // d = sat(acc + round(a*b))
    OP_DET,   // d = sat(acc - round(a*b)), sets singular flag
    OP_ADD,   // d = sat(a + b)
    OP_SUB,   // d = sat(a - b)
    OP_DIV,   // d = sat(a * ONE / b)
    OP_DIVN   // d = sat(-a * ONE / b)
  } kf_op_t;

  typedef struct packed {
    kf_op_t     op;
    logic [5:0] a;
    logic [5:0] b;
    logic [5:0] d;
  } kf_uop_t;

  // Operand address map: 0..31 named sources, 32..63 scratch memory
  localparam logic [5:0] AD_A0 = 6'd0,  AD_A1 = 6'd1,  AD_A2 = 6'd2,  AD_A3 = 6'd3;
  localparam logic [5:0] AD_H0 = 6'd4,  AD_H1 = 6'd5,  AD_H2 = 6'd6,  AD_H3 = 6'd7;
  localparam logic [5:0] AD_Q0 = 6'd8,  AD_Q1 = 6'd9,  AD_Q2 = 6'd10, AD_Q3 = 6'd11;
  localparam logic [5:0] AD_R0 = 6'd12, AD_R1 = 6'd13, AD_R2 = 6'd14, AD_R3 = 6'd15;
  localparam logic [5:0] AD_Z0 = 6'd16, AD_Z1 = 6'd17, AD_ONE = 6'd18, AD_ZR = 6'd19;
  localparam logic [5:0] AD_X0 = 6'd20, AD_X1 = 6'd21;
  localparam logic [5:0] AD_P0 = 6'd22, AD_P1 = 6'd23, AD_P2 = 6'd24, AD_P3 = 6'd25;
  localparam logic [5:0] AD_XM0 = 6'd32, AD_XM1 = 6'd33;
  localparam logic [5:0] AD_T0 = 6'd34, AD_T1 = 6'd35, AD_T2 = 6'd36, AD_T3 = 6'd37;
  localparam logic [5:0] AD_PM0 = 6'd38, AD_PM1 = 6'd39, AD_PM2 = 6'd40, AD_PM3 = 6'd41;
  localparam logic [5:0] AD_S0 = 6'd42, AD_S1 = 6'd43, AD_S2 = 6'd44, AD_S3 = 6'd45;
  localparam logic [5:0] AD_DET = 6'd46;
  localparam logic [5:0] AD_I0 = 6'd47, AD_I1 = 6'd48, AD_I2 = 6'd49, AD_I3 = 6'd50;
  localparam logic [5:0] AD_K0 = 6'd51, AD_K1 = 6'd52, AD_K2 = 6'd53, AD_K3 = 6'd54;
  localparam logic [5:0] AD_V0 = 6'd55, AD_V1 = 6'd56, AD_KV0 = 6'd57, AD_KV1 = 6'd58;
  localparam logic [5:0] AD_M0 = 6'd59, AD_M1 = 6'd60, AD_M2 = 6'd61, AD_M3 = 6'd62;

  localparam int PROG_LEN = 98;
  localparam logic [6:0] PC_LAST = 7'(PROG_LEN - 1);

  // Microprogram for one filter step
  function automatic kf_uop_t kf_ucode(input logic [6:0] pc);
    kf_uop_t u;
    case (pc)
      // xm = A*x
      7'd0:  u = '{OP_MUL, AD_A0, AD_X0, AD_ZR};
      7'd1:  u = '{OP_MAC, AD_A1, AD_X1, AD_XM0};
      7'd2:  u = '{OP_MUL, AD_A2, AD_X0, AD_ZR};
      7'd3:  u = '{OP_MAC, AD_A3, AD_X1, AD_XM1};
      // t = A*P
      7'd4:  u = '{OP_MUL, AD_A0, AD_P0, AD_ZR};
      7'd5:  u = '{OP_MAC, AD_A1, AD_P2, AD_T0};
      7'd6:  u = '{OP_MUL, AD_A0, AD_P1, AD_ZR};
      7'd7:  u = '{OP_MAC, AD_A1, AD_P3, AD_T1};
      7'd8:  u = '{OP_MUL, AD_A2, AD_P0, AD_ZR};
      7'd9:  u = '{OP_MAC, AD_A3, AD_P2, AD_T2};
      7'd10: u = '{OP_MUL, AD_A2, AD_P1, AD_ZR};
      7'd11: u = '{OP_MAC, AD_A3, AD_P3, AD_T3};
      // pm = t*A^T
      7'd12: u = '{OP_MUL, AD_T0, AD_A0, AD_ZR};
      7'd13: u = '{OP_MAC, AD_T1, AD_A1, AD_PM0};
      7'd14: u = '{OP_MUL, AD_T0, AD_A2, AD_ZR};
      7'd15: u = '{OP_MAC, AD_T1, AD_A3, AD_PM1};
      7'd16: u = '{OP_MUL, AD_T2, AD_A0, AD_ZR};
      7'd17: u = '{OP_MAC, AD_T3, AD_A1, AD_PM2};
      7'd18: u = '{OP_MUL, AD_T2, AD_A2, AD_ZR};
      7'd19: u = '{OP_MAC, AD_T3, AD_A3, AD_PM3};
      // pm += Q
      7'd20: u = '{OP_ADD, AD_PM0, AD_Q0, AD_PM0};
      7'd21: u = '{OP_ADD, AD_PM1, AD_Q1, AD_PM1};
      7'd22: u = '{OP_ADD, AD_PM2, AD_Q2, AD_PM2};
      7'd23: u = '{OP_ADD, AD_PM3, AD_Q3, AD_PM3};
      // t = H*pm
      7'd24: u = '{OP_MUL, AD_H0, AD_PM0, AD_ZR};
      7'd25: u = '{OP_MAC, AD_H1, AD_PM2, AD_T0};
      7'd26: u = '{OP_MUL, AD_H0, AD_PM1, AD_ZR};
      7'd27: u = '{OP_MAC, AD_H1, AD_PM3, AD_T1};
      7'd28: u = '{OP_MUL, AD_H2, AD_PM0, AD_ZR};
      7'd29: u = '{OP_MAC, AD_H3, AD_PM2, AD_T2};
      7'd30: u = '{OP_MUL, AD_H2, AD_PM1, AD_ZR};
      7'd31: u = '{OP_MAC, AD_H3, AD_PM3, AD_T3};
      // s = t*H^T
      7'd32: u = '{OP_MUL, AD_T0, AD_H0, AD_ZR};
      7'd33: u = '{OP_MAC, AD_T1, AD_H1, AD_S0};
      7'd34: u = '{OP_MUL, AD_T0, AD_H2, AD_ZR};
      7'd35: u = '{OP_MAC, AD_T1, AD_H3, AD_S1};
      7'd36: u = '{OP_MUL, AD_T2, AD_H0, AD_ZR};
      7'd37: u = '{OP_MAC, AD_T3, AD_H1, AD_S2};
      7'd38: u = '{OP_MUL, AD_T2, AD_H2, AD_ZR};
      7'd39: u = '{OP_MAC, AD_T3, AD_H3, AD_S3};
      // s += R
      7'd40: u = '{OP_ADD, AD_S0, AD_R0, AD_S0};
      7'd41: u = '{OP_ADD, AD_S1, AD_R1, AD_S1};
      7'd42: u = '{OP_ADD, AD_S2, AD_R2, AD_S2};
      7'd43: u = '{OP_ADD, AD_S3, AD_R3, AD_S3};
      // determinant and inverse
      7'd44: u = '{OP_MUL,  AD_S0, AD_S3,  AD_ZR};
      7'd45: u = '{OP_DET,  AD_S1, AD_S2,  AD_DET};
      7'd46: u = '{OP_DIV,  AD_S3, AD_DET, AD_I0};
      7'd47: u = '{OP_DIVN, AD_S1, AD_DET, AD_I1};
      7'd48: u = '{OP_DIVN, AD_S2, AD_DET, AD_I2};
      7'd49: u = '{OP_DIV,  AD_S0, AD_DET, AD_I3};
      // t = pm*H^T
      7'd50: u = '{OP_MUL, AD_PM0, AD_H0, AD_ZR};
      7'd51: u = '{OP_MAC, AD_PM1, AD_H1, AD_T0};
      7'd52: u = '{OP_MUL, AD_PM0, AD_H2, AD_ZR};
      7'd53: u = '{OP_MAC, AD_PM1, AD_H3, AD_T1};
      7'd54: u = '{OP_MUL, AD_PM2, AD_H0, AD_ZR};
      7'd55: u = '{OP_MAC, AD_PM3, AD_H1, AD_T2};
      7'd56: u = '{OP_MUL, AD_PM2, AD_H2, AD_ZR};
      7'd57: u = '{OP_MAC, AD_PM3, AD_H3, AD_T3};
      // k = t*inv
      7'd58: u = '{OP_MUL, AD_T0, AD_I0, AD_ZR};
      7'd59: u = '{OP_MAC, AD_T1, AD_I2, AD_K0};
      7'd60: u = '{OP_MUL, AD_T0, AD_I1, AD_ZR};
      7'd61: u = '{OP_MAC, AD_T1, AD_I3, AD_K1};
      7'd62: u = '{OP_MUL, AD_T2, AD_I0, AD_ZR};
      7'd63: u = '{OP_MAC, AD_T3, AD_I2, AD_K2};
      7'd64: u = '{OP_MUL, AD_T2, AD_I1, AD_ZR};
      7'd65: u = '{OP_MAC, AD_T3, AD_I3, AD_K3};
      // innovation v = z - H*xm
      7'd66: u = '{OP_MUL, AD_H0, AD_XM0, AD_ZR};
      7'd67: u = '{OP_MAC, AD_H1, AD_XM1, AD_V0};
      7'd68: u = '{OP_MUL, AD_H2, AD_XM0, AD_ZR};
      7'd69: u = '{OP_MAC, AD_H3, AD_XM1, AD_V1};
      7'd70: u = '{OP_SUB, AD_Z0, AD_V0, AD_V0};
      7'd71: u = '{OP_SUB, AD_Z1, AD_V1, AD_V1};
      // x = xm + K*v
      7'd72: u = '{OP_MUL, AD_K0, AD_V0, AD_ZR};
      7'd73: u = '{OP_MAC, AD_K1, AD_V1, AD_KV0};
      7'd74: u = '{OP_MUL, AD_K2, AD_V0, AD_ZR};
      7'd75: u = '{OP_MAC, AD_K3, AD_V1, AD_KV1};
      7'd76: u = '{OP_ADD, AD_XM0, AD_KV0, AD_X0};
      7'd77: u = '{OP_ADD, AD_XM1, AD_KV1, AD_X1};
      // t = K*H
      7'd78: u = '{OP_MUL, AD_K0, AD_H0, AD_ZR};
      7'd79: u = '{OP_MAC, AD_K1, AD_H2, AD_T0};
      7'd80: u = '{OP_MUL, AD_K0, AD_H1, AD_ZR};
      7'd81: u = '{OP_MAC, AD_K1, AD_H3, AD_T1};
      7'd82: u = '{OP_MUL, AD_K2, AD_H0, AD_ZR};
      7'd83: u = '{OP_MAC, AD_K3, AD_H2, AD_T2};
      7'd84: u = '{OP_MUL, AD_K2, AD_H1, AD_ZR};
      7'd85: u = '{OP_MAC, AD_K3, AD_H3, AD_T3};
      // m = I - t
      7'd86: u = '{OP_SUB, AD_ONE, AD_T0, AD_M0};
      7'd87: u = '{OP_SUB, AD_ZR,  AD_T1, AD_M1};
      7'd88: u = '{OP_SUB, AD_ZR,  AD_T2, AD_M2};
      7'd89: u = '{OP_SUB, AD_ONE, AD_T3, AD_M3};
      // P = m*pm
      7'd90: u = '{OP_MUL, AD_M0, AD_PM0, AD_ZR};
      7'd91: u = '{OP_MAC, AD_M1, AD_PM2, AD_P0};
      7'd92: u = '{OP_MUL, AD_M0, AD_PM1, AD_ZR};
      7'd93: u = '{OP_MAC, AD_M1, AD_PM3, AD_P1};
      7'd94: u = '{OP_MUL, AD_M2, AD_PM0, AD_ZR};
      7'd95: u = '{OP_MAC, AD_M3, AD_PM2, AD_P2};
      7'd96: u = '{OP_MUL, AD_M2, AD_PM1, AD_ZR};
      7'd97: u = '{OP_MAC, AD_M3, AD_PM3, AD_P3};
      default: u = '{OP_MUL, AD_ZR, AD_ZR, AD_ZR};
    endcase
    return u;
  endfunction

  // Saturate to 32-bit signed
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sh0000_0000_7FFF_FFFF) r = 32'sh7FFF_FFFF;
    else if (v < -64'sh0000_0000_8000_0000) r = -32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

@@ rtl/kalman_filter_2x2.sv @@
// Two-state linear Kalman filter, signed fixed point with FRAC_BITS fraction bits.
// Input stream: in_tdata carries a measurement pair; each transaction runs one
// predict/update step. Output stream: out_tdata carries the updated state and
// out_tuser flags a singular innovation covariance (gain forced to zero).
// Configuration: cfg_valid/cfg_index/cfg_data write A, H, Q, R rows; the user
// must write them while idle, which the block itself does not enforce.
// Unlisted indexes are dropped. cfg_ready is always high.
// Sequence: one step is a microprogram of 98 operations on one shared 32x32
// multiplier with round/saturate, each passing the read, execute and write-back
// states, plus four divisions on a radix-2 restoring divider, each with its own
// write-back state. A singular step skips the divider. in_tready is high only in
// the idle state, so an item is accepted only once the previous step has finished.
// Stall: the result sits in an output register; the next item is accepted
// while it waits, and that item's result is held back until the register frees.
// Reset: rst_n (synchronous, active low) clears the state vector and covariance
// to zero, sets A, H, R to diag(1 LSB, 2^16 LSB) and Q to zero, drops any result.
module kalman_filter_2x2
  import kf2_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [31:0] meas_first, [63:32] meas_second
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [31:0] est_first, [63:32] est_second
  output logic        out_tuser,  // [0] singular
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  localparam int NW = 32 + FRAC_BITS;
  localparam int CW = $clog2(NW);
  localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [31:0] ONE_Q = 32'sd1 <<< FRAC_BITS;

  kf_state_t state_r, state_nxt;

  logic [63:0] trans0_r, trans1_r, obs0_r, obs1_r;
  logic [63:0] pns0_r, pns1_r, mns0_r, mns1_r;
  logic signed [31:0] z0_r, z1_r;
  logic signed [31:0] x0_r, x1_r, p0_r, p1_r, p2_r, p3_r;
  logic [6:0] pc_r;
  kf_uop_t uop;

  logic signed [31:0] mem [32];
  logic signed [31:0] mema_r, memb_r, misca_r, miscb_r;
  logic signed [31:0] opa_r, opb_r;
  logic signed [63:0] prod_r, acc_r;
  logic sing_r;

  logic [NW-1:0] dnum_r, dquo_r;
  logic [31:0]   drem_r, dden_r;
  logic          dneg_r;
  logic [CW-1:0] dcnt_r;

  logic               out_tvalid_r;
  logic [63:0]        out_tdata_r;
  logic               out_tuser_r;

  logic               wr_en;
  logic signed [31:0] wr_data;
  logic signed [63:0] rnd;
  logic signed [31:0] opa, opb;
  logic               is_div;
  logic [32:0]        trial;
  logic               qbit;
  logic signed [32:0] adj, adj_mag, den_s;

  assign uop       = kf_ucode(pc_r);
  assign in_tready = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  // Named operand sources: config elements, input, constants, state
  function automatic logic signed [31:0] src_sel(input logic [5:0] ad);
    logic signed [31:0] v;
    case (ad)
      AD_A0:  v = trans0_r[63:32];
      AD_A1:  v = trans0_r[31:0];
      AD_A2:  v = trans1_r[63:32];
      AD_A3:  v = trans1_r[31:0];
      AD_H0:  v = obs0_r[63:32];
      AD_H1:  v = obs0_r[31:0];
      AD_H2:  v = obs1_r[63:32];
      AD_H3:  v = obs1_r[31:0];
      AD_Q0:  v = pns0_r[63:32];
      AD_Q1:  v = pns0_r[31:0];
      AD_Q2:  v = pns1_r[63:32];
      AD_Q3:  v = pns1_r[31:0];
      AD_R0:  v = mns0_r[63:32];
      AD_R1:  v = mns0_r[31:0];
      AD_R2:  v = mns1_r[63:32];
      AD_R3:  v = mns1_r[31:0];
      AD_Z0:  v = z0_r;
      AD_Z1:  v = z1_r;
      AD_ONE: v = ONE_Q;
      AD_X0:  v = x0_r;
      AD_X1:  v = x1_r;
      AD_P0:  v = p0_r;
      AD_P1:  v = p1_r;
      AD_P2:  v = p2_r;
      AD_P3:  v = p3_r;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Operand select after the registered reads
  assign opa = uop.a[5] ? mema_r : misca_r;
  assign opb = uop.b[5] ? memb_r : miscb_r;

  // Rounded product, half up
  assign rnd    = (prod_r + HALF) >>> FRAC_BITS;
  assign is_div = (uop.op == OP_DIV) || (uop.op == OP_DIVN);

  // Divider setup values
  assign adj     = (uop.op == OP_DIVN) ? -33'(opa_r) : 33'(opa_r);
  assign adj_mag = adj[32] ? -adj : adj;
  assign den_s   = opb_r[31] ? -33'(opb_r) : 33'(opb_r);

  // Divider step
  assign trial = {drem_r, dnum_r[NW-1]};
  assign qbit  = (trial >= {1'b0, dden_r});

  // Next state and result write
  always_comb begin
    state_nxt = state_r;
    wr_en     = 1'b0;
    wr_data   = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_RD;
      end
      ST_RD: state_nxt = ST_EX;
      ST_EX: state_nxt = ST_WB;
      ST_WB: begin
        case (uop.op)
          OP_MAC: begin
            wr_en   = 1'b1;
            wr_data = sat32(acc_r + rnd);
          end
          OP_DET: begin
            wr_en   = 1'b1;
            wr_data = sat32(acc_r - rnd);
          end
          OP_ADD: begin
            wr_en   = 1'b1;
            wr_data = sat32(64'(opa_r) + 64'(opb_r));
          end
          OP_SUB: begin
            wr_en   = 1'b1;
            wr_data = sat32(64'(opa_r) - 64'(opb_r));
          end
          OP_DIV, OP_DIVN: begin
            // zero gain when singular
            wr_en   = sing_r;
            wr_data = '0;
          end
          default: wr_en = 1'b0;
        endcase
        if (is_div && !sing_r) state_nxt = ST_DIV;
        else if (pc_r == PC_LAST) state_nxt = ST_OUT;
        else state_nxt = ST_RD;
      end
      ST_DIV: begin
        if (dcnt_r == CW'(NW - 1)) state_nxt = ST_DWB;
      end
      ST_DWB: begin
        wr_en = 1'b1;
        if (!dneg_r) begin
          wr_data = (dquo_r > NW'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : dquo_r[31:0];
        end else begin
          wr_data = (dquo_r > NW'(33'h0_8000_0000)) ? -32'sh8000_0000
                                                     : -dquo_r[31:0];
        end
        state_nxt = (pc_r == PC_LAST) ? ST_OUT : ST_RD;
      end
      ST_OUT: begin
        if (!out_tvalid_r) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trans0_r <= RST_ROW0;
      trans1_r <= RST_ROW1;
      obs0_r   <= RST_ROW0;
      obs1_r   <= RST_ROW1;
      pns0_r   <= RST_ZERO;
      pns1_r   <= RST_ZERO;
      mns0_r   <= RST_ROW0;
      mns1_r   <= RST_ROW1;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_TRANS0: trans0_r <= cfg_data;
        REG_TRANS1: trans1_r <= cfg_data;
        REG_OBS0:   obs0_r   <= cfg_data;
        REG_OBS1:   obs1_r   <= cfg_data;
        REG_PNS0:   pns0_r   <= cfg_data;
        REG_PNS1:   pns1_r   <= cfg_data;
        REG_MNS0:   mns0_r   <= cfg_data;
        REG_MNS1:   mns1_r   <= cfg_data;
        default:    ;
      endcase
    end
  end

  // Program counter: clear on accept, advance after each write-back
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= '0;
    end else if (state_r == ST_IDLE && in_tvalid) begin
      pc_r <= '0;
    end else if ((state_r == ST_WB && state_nxt != ST_DIV) || state_r == ST_DWB) begin
      pc_r <= pc_r + 7'd1;
    end
  end

  // Capture measurement
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_tvalid) begin
      z0_r <= in_tdata[31:0];
      z1_r <= in_tdata[63:32];
    end
  end

  // Scratch memory: two registered reads, one write
  always_ff @(posedge clk) begin
    if (state_r == ST_RD) begin
      mema_r <= mem[uop.a[4:0]];
      memb_r <= mem[uop.b[4:0]];
    end
    if (wr_en && uop.d[5]) mem[uop.d[4:0]] <= wr_data;
  end

  // Filter state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x0_r <= '0;
      x1_r <= '0;
      p0_r <= '0;
      p1_r <= '0;
      p2_r <= '0;
      p3_r <= '0;
    end else if (wr_en && !uop.d[5]) begin
      case (uop.d)
        AD_X0:   x0_r <= wr_data;
        AD_X1:   x1_r <= wr_data;
        AD_P0:   p0_r <= wr_data;
        AD_P1:   p1_r <= wr_data;
        AD_P2:   p2_r <= wr_data;
        AD_P3:   p3_r <= wr_data;
        default: ;
      endcase
    end
  end

  // Shared multiplier and accumulator
  always_ff @(posedge clk) begin
    if (state_r == ST_RD) begin
      misca_r <= src_sel(uop.a);
      miscb_r <= src_sel(uop.b);
    end
    if (state_r == ST_EX) begin
      opa_r  <= opa;
      opb_r  <= opb;
      prod_r <= 64'(opa) * 64'(opb);
    end
    if (state_r == ST_WB && uop.op == OP_MUL) acc_r <= rnd;
  end

  // Singular flag, set by the determinant write
  always_ff @(posedge clk) begin
    if (!rst_n) sing_r <= 1'b0;
    else if (state_r == ST_WB && uop.op == OP_DET) sing_r <= (wr_data == '0);
  end

  // Restoring divider, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (state_r == ST_WB) begin
      dnum_r <= NW'(adj_mag[31:0]) << FRAC_BITS;
      dden_r <= den_s[31:0];
      dneg_r <= adj[32] ^ opb_r[31];
      drem_r <= '0;
      dquo_r <= '0;
      dcnt_r <= '0;
    end else if (state_r == ST_DIV) begin
      drem_r <= qbit ? 32'(trial - {1'b0, dden_r}) : trial[31:0];
      dnum_r <= {dnum_r[NW-2:0], 1'b0};
      dquo_r <= {dquo_r[NW-2:0], qbit};
      dcnt_r <= dcnt_r + CW'(1);
    end
  end

  // Output register: load when free, hold while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (state_r == ST_OUT && !out_tvalid_r) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_OUT && !out_tvalid_r) begin
      out_tdata_r <= {x1_r, x0_r};
      out_tuser_r <= sing_r;
    end
  end

  // Sequencer never runs past the program while it executes
  a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE && state_r != ST_OUT) |-> (pc_r <= PC_LAST))
    else $error("program counter past end of program");

  // Divider stays within its bit count
  a_div_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (dcnt_r <= CW'(NW - 1)))
    else $error("divider ran past quotient width");

  // Division only entered on a nonsingular divide operation
  a_div_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WB && state_nxt == ST_DIV) |-> (is_div && !sing_r))
    else $error("divider started without a divide operation");

  // An accepted item starts the sequencer from the top
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == ST_RD && pc_r == '0))
    else $error("item accepted without program restart");

endmodule

@@ dv/tb.sv @@
module tb;
  import kf2_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = FRAC_BITS_DEF;
  localparam longint ONE_Q = 64'sd1 <<< FRAC;
  localparam longint HALF_Q = 64'sd1 <<< (FRAC - 1);
  localparam int STALL_LIMIT = 20000;
  localparam int HOLD_CYCLES = 3000;
  localparam int NUM_SEGMENTS = 12;
  localparam int SEG_ITEMS = 119;
  // index outside the register map; a write there must be dropped
  localparam logic [3:0] REG_UNMAPPED = 4'd12;

  typedef enum logic {ROW_MEAS, ROW_REG} row_kind_t;

  typedef struct {
    row_kind_t          kind;
    logic [3:0]         idx;
    logic [63:0]        data;
    logic signed [31:0] z0;
    logic signed [31:0] z1;
    bit                 typed;
    logic signed [31:0] e0;
    logic signed [31:0] e1;
    logic               sing;
  } dir_row_t;

  typedef struct {
    logic signed [31:0] e0;
    logic signed [31:0] e1;
    logic               sing;
  } estimate_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;
  logic        out_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [3:0]  cfg_index;
  logic [63:0] cfg_data;

  // filter mirror: register shadow, state vector, covariance
  logic [63:0]        reg_shadow[8];
  logic signed [31:0] x_est[2];
  logic signed [31:0] p_cov[4];

  estimate_t expected_est[$];
  int errors = 0;
  int steps_sent;
  int steps_seen = 0;
  int singular_seen = 0;
  int settings_used;
  int tx_idle_pct;
  int rx_idle_pct;
  bit hold_req;
  int hold_cnt = 0;
  int quiet_cycles = 0;

  kalman_filter_2x2 DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // round half up: floor((a*b + half) / 2^FRAC)
  function automatic longint qmul(longint a, longint b);
    return (a * b + HALF_Q) >>> FRAC;
  endfunction

  function automatic longint dot2(longint a0, longint b0, longint a1, longint b1);
    return clip32(qmul(a0, b0) + qmul(a1, b1));
  endfunction

  // column 0 in the upper word, column 1 in the lower
  function automatic longint elem(logic [63:0] w, int col);
    return (col == 0) ? longint'($signed(w[63:32])) : longint'($signed(w[31:0]));
  endfunction

  // one predict/update step on the mirrored state
  task automatic kf_predict(input logic signed [31:0] z0, input logic signed [31:0] z1,
                            output estimate_t est);
    longint a[4], h[4], q[4], r[4], p[4], pm[4], t[4], s[4], k[4], m[4], inv[4], np[4];
    longint xm[2], hx[2], v[2], kv[2], xn[2];
    longint det;
    for (int i = 0; i < 4; i++) begin
      a[i] = elem(reg_shadow[REG_TRANS0 + i / 2], i % 2);
      h[i] = elem(reg_shadow[REG_OBS0 + i / 2], i % 2);
      q[i] = elem(reg_shadow[REG_PNS0 + i / 2], i % 2);
      r[i] = elem(reg_shadow[REG_MNS0 + i / 2], i % 2);
      p[i] = p_cov[i];
      k[i] = 0;
    end
    // predict
    xm[0] = dot2(a[0], x_est[0], a[1], x_est[1]);
    xm[1] = dot2(a[2], x_est[0], a[3], x_est[1]);
    for (int i = 0; i < 2; i++)
      for (int j = 0; j < 2; j++)
        t[2*i+j] = dot2(a[2*i], p[j], a[2*i+1], p[2+j]);
    for (int i = 0; i < 2; i++)
      for (int j = 0; j < 2; j++)
        pm[2*i+j] = clip32(dot2(t[2*i], a[2*j], t[2*i+1], a[2*j+1]) + q[2*i+j]);
    // innovation covariance
    for (int i = 0; i < 2; i++)
      for (int j = 0; j < 2; j++)
        t[2*i+j] = dot2(h[2*i], pm[j], h[2*i+1], pm[2+j]);
    for (int i = 0; i < 2; i++)
      for (int j = 0; j < 2; j++)
        s[2*i+j] = clip32(dot2(t[2*i], h[2*j], t[2*i+1], h[2*j+1]) + r[2*i+j]);
    det = clip32(qmul(s[0], s[3]) - qmul(s[1], s[2]));
    est.sing = (det == 0);
    // gain through adjugate over determinant; zero gain when singular
    if (!est.sing) begin
      inv[0] = clip32((s[3] * ONE_Q) / det);
      inv[1] = clip32((-s[1] * ONE_Q) / det);
      inv[2] = clip32((-s[2] * ONE_Q) / det);
      inv[3] = clip32((s[0] * ONE_Q) / det);
      for (int i = 0; i < 2; i++)
        for (int j = 0; j < 2; j++)
          t[2*i+j] = dot2(pm[2*i], h[2*j], pm[2*i+1], h[2*j+1]);
      for (int i = 0; i < 2; i++)
        for (int j = 0; j < 2; j++)
          k[2*i+j] = dot2(t[2*i], inv[j], t[2*i+1], inv[2+j]);
    end
    // state update
    hx[0] = dot2(h[0], xm[0], h[1], xm[1]);
    hx[1] = dot2(h[2], xm[0], h[3], xm[1]);
    v[0] = clip32(longint'(z0) - hx[0]);
    v[1] = clip32(longint'(z1) - hx[1]);
    kv[0] = dot2(k[0], v[0], k[1], v[1]);
    kv[1] = dot2(k[2], v[0], k[3], v[1]);
    xn[0] = clip32(xm[0] + kv[0]);
    xn[1] = clip32(xm[1] + kv[1]);
    // covariance update
    for (int i = 0; i < 2; i++)
      for (int j = 0; j < 2; j++)
        t[2*i+j] = dot2(k[2*i], h[j], k[2*i+1], h[2+j]);
    m[0] = clip32(ONE_Q - t[0]);
    m[1] = clip32(-t[1]);
    m[2] = clip32(-t[2]);
    m[3] = clip32(ONE_Q - t[3]);
    for (int i = 0; i < 2; i++)
      for (int j = 0; j < 2; j++)
        np[2*i+j] = dot2(m[2*i], pm[j], m[2*i+1], pm[2+j]);
    for (int i = 0; i < 4; i++) p_cov[i] = np[i][31:0];
    x_est[0] = xn[0][31:0];
    x_est[1] = xn[1][31:0];
    est.e0 = x_est[0];
    est.e1 = x_est[1];
  endtask

  // offer one measurement pair and hold until the transaction completes
  task automatic send_meas(input logic signed [31:0] z0, input logic signed [31:0] z1,
                           input bit typed, input estimate_t typed_est);
    estimate_t est;
    int gap;
    in_tvalid <= 1'b1;
    in_tdata  <= {z1, z0};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    kf_predict(z0, z1, est);
    expected_est.push_back(typed ? typed_est : est);
    steps_sent++;
    // idle the sender at random
    gap = ($urandom_range(0, 99) < tx_idle_pct) ? $urandom_range(1, 20) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // drain all results, then let the block settle before touching registers
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_est.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // one register write, then a quiet configuration port before the task returns
  task automatic write_reg(input logic [3:0] idx, input logic [63:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx <= REG_MNS1) reg_shadow[idx] = data;
    @(posedge clk);
  endtask

  function automatic logic [31:0] rand_elem(int mode);
    logic [31:0] pick[4];
    pick = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0001_0000};
    case (mode)
      0:       return 32'($urandom_range(0, 1 << 18)) - 32'(1 << 17);
      1:       return $urandom;
      default: return pick[$urandom_range(0, 3)];
    endcase
  endfunction

  function automatic logic signed [31:0] rand_meas();
    if ($urandom_range(0, 9) == 0) return $urandom;
    return 32'($urandom_range(0, 1 << 22)) - 32'(1 << 21);
  endfunction

  // result checking, receiver stalls and the stall watchdog
  always @(posedge clk) begin
    estimate_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
        $display("FAIL");
        $finish;
      end
      if (out_tvalid && out_tready) begin
        steps_seen++;
        if (expected_est.size() == 0) begin
          $error("unexpected result est_first %0d est_second %0d",
                 $signed(out_tdata[31:0]), $signed(out_tdata[63:32]));
          errors++;
        end else begin
          want = expected_est.pop_front();
          if (out_tdata[31:0] !== want.e0) begin
            $error("est_first expected %0d actual %0d", want.e0, $signed(out_tdata[31:0]));
            errors++;
          end
          if (out_tdata[63:32] !== want.e1) begin
            $error("est_second expected %0d actual %0d", want.e1,
                   $signed(out_tdata[63:32]));
            errors++;
          end
          if (out_tuser !== want.sing) begin
            $error("singular expected %0d actual %0d", want.sing, out_tuser);
            errors++;
          end
          if (want.sing) singular_seen++;
        end
      end
      // long hold-off so the block fills and back-pressures its input
      if (hold_req && hold_cnt < HOLD_CYCLES) begin
        hold_cnt <= hold_cnt + 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  initial begin
    dir_row_t  rows[$];
    estimate_t typed_est;
    estimate_t zero_est;
    int mode;
    steps_sent = 0;
    settings_used = 1;
    tx_idle_pct = 29;
    rx_idle_pct = 53;
    hold_req = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    reg_shadow = '{RST_ROW0, RST_ROW1, RST_ROW0, RST_ROW1, RST_ZERO, RST_ZERO,
                   RST_ROW0, RST_ROW1};
    x_est = '{0, 0};
    p_cov = '{0, 0, 0, 0};
    zero_est = '{0, 0, 1'b0};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // after reset P is zero, so the gain is zero and the estimate stays at zero
    rows.push_back('{ROW_MEAS, 0, 0, 0, 0, 1, 0, 0, 0});
    rows.push_back('{ROW_MEAS, 0, 0, 32'sh7FFF_FFFF, 32'sh8000_0000, 1, 0, 0, 0});
    rows.push_back('{ROW_MEAS, 0, 0, 32'sh8000_0000, 32'sh7FFF_FFFF, 1, 0, 0, 0});
    rows.push_back('{ROW_MEAS, 0, 0, 1, -1, 1, 0, 0, 0});
    // zero R with zero P gives a singular innovation covariance
    rows.push_back('{ROW_REG, REG_MNS0, RST_ZERO, 0, 0, 0, 0, 0, 0});
    rows.push_back('{ROW_REG, REG_MNS1, RST_ZERO, 0, 0, 0, 0, 0, 0});
    rows.push_back('{ROW_MEAS, 0, 0, 123, 456, 1, 0, 0, 1});
    rows.push_back('{ROW_MEAS, 0, 0, 32'sh8000_0000, 32'sh8000_0000, 1, 0, 0, 1});
    // unmapped index is dropped
    rows.push_back('{ROW_REG, REG_UNMAPPED, '1, 0, 0, 0, 0, 0, 0});
    rows.push_back('{ROW_MEAS, 0, 0, 7, 9, 1, 0, 0, 1});
    // Q, R = diag(1 LSB, 2^16 LSB): the filter starts to follow measurements
    rows.push_back('{ROW_REG, REG_PNS0, RST_ROW0, 0, 0, 0, 0, 0, 0});
    rows.push_back('{ROW_REG, REG_PNS1, RST_ROW1, 0, 0, 0, 0, 0, 0});
    rows.push_back('{ROW_REG, REG_MNS0, RST_ROW0, 0, 0, 0, 0, 0, 0});
    rows.push_back('{ROW_REG, REG_MNS1, RST_ROW1, 0, 0, 0, 0, 0, 0});
    rows.push_back('{ROW_MEAS, 0, 0, 32'sh0001_0000, -32'sh0001_0000, 0, 0, 0, 0});
    rows.push_back('{ROW_MEAS, 0, 0, 32'sh7FFF_FFFF, 32'sh8000_0000, 0, 0, 0, 0});
    rows.push_back('{ROW_MEAS, 0, 0, 32'sh8000_0000, 32'sh7FFF_FFFF, 0, 0, 0, 0});
    // extreme transition and observation rows drive saturation
    rows.push_back('{ROW_REG, REG_TRANS0, '1, 0, 0, 0, 0, 0, 0});
    rows.push_back('{ROW_REG, REG_TRANS1, 64'h7FFF_FFFF_8000_0000, 0, 0, 0, 0, 0, 0});
    rows.push_back('{ROW_REG, REG_OBS0, 64'h8000_0000_7FFF_FFFF, 0, 0, 0, 0, 0, 0});
    rows.push_back('{ROW_MEAS, 0, 0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0, 0, 0, 0});
    rows.push_back('{ROW_MEAS, 0, 0, 32'sh8000_0000, 0, 0, 0, 0, 0});
    rows.push_back('{ROW_MEAS, 0, 0, 32'sh1234_5678, -32'sh0765_4321, 0, 0, 0, 0});

    foreach (rows[n]) begin
      if (rows[n].kind == ROW_REG) begin
        wait_idle();
        write_reg(rows[n].idx, rows[n].data);
      end else begin
        typed_est = '{rows[n].e0, rows[n].e1, rows[n].sing};
        send_meas(rows[n].z0, rows[n].z1, rows[n].typed, typed_est);
      end
    end

    // random segments, each under a fresh register setting
    for (int seg = 0; seg < NUM_SEGMENTS; seg++) begin
      wait_idle();
      if (seg < 4) begin
        tx_idle_pct = 29;
        rx_idle_pct = 53;
      end else if (seg < 8) begin
        tx_idle_pct = 53;
        rx_idle_pct = 29;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      for (int i = 0; i <= REG_MNS1; i++) begin
        case (seg)
          1:       write_reg(i[3:0], RST_ZERO);
          2:       write_reg(i[3:0], '1);
          default: begin
            mode = (seg % 3 == 0) ? 0 : ((seg % 3 == 1) ? 1 : 2);
            if (mode == 0 && (i == REG_TRANS0 || i == REG_OBS0 || i == REG_MNS0))
              write_reg(i[3:0], {32'h0001_0000 + rand_elem(0), rand_elem(0)});
            else if (mode == 0 && (i == REG_TRANS1 || i == REG_OBS1 || i == REG_MNS1))
              write_reg(i[3:0], {rand_elem(0), 32'h0001_0000 + rand_elem(0)});
            else
              write_reg(i[3:0], {rand_elem(mode), rand_elem(mode)});
          end
        endcase
      end
      settings_used++;
      if (seg == 5) begin
        hold_req = 1'b1;
      end
      for (int i = 0; i < SEG_ITEMS; i++) begin
        zero_est = '{0, 0, 1'b0};
        send_meas(rand_meas(), rand_meas(), 1'b0, zero_est);
      end
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_est.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);

    $display("Ran %0d filter steps (%0d results, %0d singular) over %0d register settings",
             steps_sent, steps_seen, singular_seen, settings_used);
    $display("including saturating extremes, stalls on both sides and a long output hold-off");
    if (errors == 0 && expected_est.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/kf2_pkg.sv
rtl/kalman_filter_2x2.sv
dv/tb.sv
